// ===== hdl/brp_pkg.sv =====
// Shared types and constants for the blob report parser.
// Depends on nothing; the front end, queue, back end, top and testbench import it.
package brp_pkg;

  localparam logic [2:0] FMT_FULL   = 3'd1;
  localparam logic [2:0] FMT_BASIC  = 3'd2;
  localparam logic [2:0] FMT_BRIGHT = 3'd3;
  localparam logic [2:0] FMT_BOUNDS = 3'd4;

  localparam int unsigned OBJ_BYTES   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] AREA_HI_MASK = 8'h3f;
  localparam logic [7:0] CENT_HI_MASK = 8'h0f;
  localparam logic [7:0] BOUND_MASK   = 8'h7f;

  // One finished object as gathered by the front end.
  typedef struct packed {
    logic [OBJ_BYTES-1:0][7:0] bytes;
    logic [2:0]                fmt;
    logic [3:0]                index;
    logic                      last;
  } raw_obj_t;

  // Position of the final byte of an object; unknown codes use the full length.
  function automatic logic [3:0] last_byte_pos(input logic [2:0] fmt);
    logic [3:0] pos;
    unique case (fmt)
      FMT_BASIC:  pos = 4'd5;
      FMT_BRIGHT: pos = 4'd8;
      FMT_BOUNDS: pos = 4'd12;
      default:    pos = 4'd15;
    endcase
    return pos;
  endfunction

endpackage

// ===== hdl/brp_ifs.sv =====
// Channel interfaces of the blob report parser: byte input, format
// register write and decoded record output. Depends on nothing.
interface report_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte;
  modport source (output valid, output report_byte, input ready);
  modport sink   (input valid, input report_byte, output ready);
endinterface

interface format_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] report_format;
  modport source (output valid, output report_format, input ready);
  modport sink   (input valid, input report_format, output ready);
endinterface

interface blob_record_if;
  logic        valid;
  logic        ready;
  logic [13:0] blob_area;
  logic [11:0] centroid_x;
  logic [11:0] centroid_y;
  logic        object_valid;
  logic [15:0] brightness_pair;
  logic [7:0]  range_radius;
  logic [27:0] bounds_packed;
  logic [7:0]  aspect;
  logic [15:0] velocity_pair;
  logic [3:0]  object_index;
  logic        last_object;
  logic [4:0]  valid_total;
  modport source (output valid, output blob_area, output centroid_x, output centroid_y,
                  output object_valid, output brightness_pair, output range_radius,
                  output bounds_packed, output aspect, output velocity_pair,
                  output object_index, output last_object, output valid_total,
                  input ready);
  modport sink   (input valid, input blob_area, input centroid_x, input centroid_y,
                  input object_valid, input brightness_pair, input range_radius,
                  input bounds_packed, input aspect, input velocity_pair,
                  input object_index, input last_object, input valid_total,
                  output ready);
endinterface

// ===== hdl/brp_front.sv =====
// Front end: takes report bytes, holds the format register, gathers each
// object's bytes and hands a finished object to the queue. Uses brp_pkg, brp_ifs.
module brp_front
  import brp_pkg::*;
#(
  parameter int unsigned OBJECTS_PER_REPORT = 16
) (
  input  logic               clk,
  input  logic               rst,
  report_byte_if.sink        byte_in,
  format_cfg_if.sink         cfg,
  output raw_obj_t           push_data,
  output logic               push_valid,
  input  logic               push_ready
);

  localparam logic [3:0] LAST_OBJ = 4'(OBJECTS_PER_REPORT - 1);

  logic [2:0] report_format;
  logic [3:0] byte_position;
  logic [3:0] object_counter;
  logic [7:0] object_bytes [OBJ_BYTES];

  logic end_byte;
  logic take;

  // A format change mid-object may leave the position past the new end.
  assign end_byte     = byte_position >= last_byte_pos(report_format);
  assign byte_in.ready = !end_byte || push_ready;
  assign take         = byte_in.valid && byte_in.ready;
  assign push_valid   = take && end_byte;
  assign cfg.ready    = 1'b1;

  always_comb begin
    for (int i = 0; i < OBJ_BYTES; i++) begin
      push_data.bytes[i] = (4'(i) == byte_position) ? byte_in.report_byte : object_bytes[i];
    end
    push_data.fmt   = report_format;
    push_data.index = object_counter;
    push_data.last  = object_counter == LAST_OBJ;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report_format  <= FMT_FULL;
      byte_position  <= '0;
      object_counter <= '0;
    end else begin
      if (cfg.valid) begin
        report_format <= cfg.report_format;
      end
      if (take) begin
        if (end_byte) begin
          byte_position <= '0;
          object_counter <= push_data.last ? 4'd0 : object_counter + 4'd1;
        end else begin
          byte_position <= byte_position + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      object_bytes[byte_position] <= byte_in.report_byte;
    end
  end

endmodule

// ===== hdl/brp_queue.sv =====
// Two-entry queue of gathered objects between the front end and the decoder.
// Uses brp_pkg.
module brp_queue
  import brp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  raw_obj_t push_data,
  input  logic     push_valid,
  output logic     push_ready,
  output raw_obj_t head,
  output logic     head_valid,
  input  logic     pop
);

  raw_obj_t   mem [QUEUE_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = count != 2'(QUEUE_DEPTH);
  assign head_valid = count != 2'd0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push_valid) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push_valid, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    push_valid && !pop |=> count == $past(count) + 2'd1)
    else $error("push not counted");

endmodule

// ===== hdl/brp_back.sv =====
// Back end: decodes the queued object bytes into a record, keeps the
// running valid count and holds the output register. Uses brp_pkg, brp_ifs.
module brp_back
  import brp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  raw_obj_t    head,
  input  logic        head_valid,
  output logic        pop,
  blob_record_if.source record_out
);

  typedef struct packed {
    logic [13:0] blob_area;
    logic [11:0] centroid_x;
    logic [11:0] centroid_y;
    logic        object_valid;
    logic [15:0] brightness_pair;
    logic [7:0]  range_radius;
    logic [27:0] bounds_packed;
    logic [7:0]  aspect;
    logic [15:0] velocity_pair;
    logic [3:0]  object_index;
    logic        last_object;
    logic [4:0]  valid_total;
  } rec_t;

  rec_t       rec;
  rec_t       rec_next;
  logic       out_valid;
  logic [4:0] valid_counter;

  logic                      has_bright;
  logic                      has_bounds;
  logic [OBJ_BYTES-1:0][7:0] b;
  logic [7:0]                s9, s10, s11, s12, s13, s14, s15;

  assign pop = head_valid && (!out_valid || record_out.ready);

  always_comb begin
    b          = head.bytes;
    has_bright = head.fmt == FMT_FULL || head.fmt == FMT_BRIGHT;
    has_bounds = head.fmt == FMT_FULL || head.fmt == FMT_BOUNDS;
    // The short bounds layout places these fields three bytes earlier.
    if (head.fmt == FMT_BOUNDS) begin
      s9 = b[6];  s10 = b[7];  s11 = b[8];  s12 = b[9];
      s13 = b[10]; s14 = b[11]; s15 = b[12];
    end else begin
      s9 = b[9];  s10 = b[10]; s11 = b[11]; s12 = b[12];
      s13 = b[13]; s14 = b[14]; s15 = b[15];
    end

    rec_next.blob_area  = {b[1][5:0] & AREA_HI_MASK[5:0], b[0]};
    rec_next.centroid_x = {b[3][3:0] & CENT_HI_MASK[3:0], b[2]};
    rec_next.centroid_y = {b[5][3:0] & CENT_HI_MASK[3:0], b[4]};
    rec_next.object_valid = (rec_next.blob_area != '0) || (has_bright && b[7] != '0);
    rec_next.brightness_pair = has_bright ? {b[7], b[6]} : 16'd0;
    rec_next.range_radius    = has_bright ? b[8] : 8'd0;
    rec_next.bounds_packed   = has_bounds ?
        {s12[6:0] & BOUND_MASK[6:0], s11[6:0] & BOUND_MASK[6:0],
         s10[6:0] & BOUND_MASK[6:0], s9[6:0] & BOUND_MASK[6:0]} : 28'd0;
    rec_next.aspect        = has_bounds ? s13 : 8'd0;
    rec_next.velocity_pair = has_bounds ? {s15, s14} : 16'd0;
    rec_next.object_index  = head.index;
    rec_next.last_object   = head.last;
    rec_next.valid_total   = valid_counter + 5'(rec_next.object_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      valid_counter <= '0;
    end else begin
      if (pop) begin
        out_valid     <= 1'b1;
        valid_counter <= head.last ? 5'd0 : rec_next.valid_total;
      end else if (record_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec <= rec_next;
    end
  end

  assign record_out.valid           = out_valid;
  assign record_out.blob_area       = rec.blob_area;
  assign record_out.centroid_x      = rec.centroid_x;
  assign record_out.centroid_y      = rec.centroid_y;
  assign record_out.object_valid    = rec.object_valid;
  assign record_out.brightness_pair = rec.brightness_pair;
  assign record_out.range_radius    = rec.range_radius;
  assign record_out.bounds_packed   = rec.bounds_packed;
  assign record_out.aspect          = rec.aspect;
  assign record_out.velocity_pair   = rec.velocity_pair;
  assign record_out.object_index    = rec.object_index;
  assign record_out.last_object     = rec.last_object;
  assign record_out.valid_total     = rec.valid_total;

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rec.valid_total <= {1'b0, rec.object_index} + 5'd1)
    else $error("valid count exceeds object count");

  a_valid_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && rec.object_valid |-> rec.valid_total != 5'd0)
    else $error("valid object not counted");

endmodule

// ===== hdl/blob_report_parser_top.sv =====
// Blob report parser: takes a sensor's object report one byte per word on
// byte_in and returns one decoded record per object on record_out.
// The cfg channel writes report_format (1 full, 2 basic, 3 brightness,
// 4 bounds); it is always ready and should be written while the block is idle.
// Each object is 16, 6, 9 or 13 bytes; on its last byte the front end passes
// the gathered bytes into a two-entry queue and the decoder turns them into a
// record with the object index, a last-object flag and the running count of
// valid objects, which restarts after the last object of a report.
// Throughput is one byte per cycle while byte_in.ready is high; an object
// enters the queue on its final byte, then is decoded into the output register.
// Reset (rst, synchronous) clears the byte and object counters, the valid
// count and the queue, and sets the format to the full layout.
// When record_out stalls, the output register and the queue hold up to three
// records; bytes keep flowing until an object's final byte finds the queue
// full, at which point byte_in.ready drops until the queue frees an entry.
module blob_report_parser_top
  import brp_pkg::*;
#(
  parameter int unsigned OBJECTS_PER_REPORT = 16
) (
  input  logic            clk,
  input  logic            rst,
  report_byte_if.sink     byte_in,
  format_cfg_if.sink      cfg,
  blob_record_if.source   record_out
);

  raw_obj_t push_data;
  logic     push_valid;
  logic     push_ready;
  raw_obj_t head;
  logic     head_valid;
  logic     pop;

  brp_front #(
    .OBJECTS_PER_REPORT(OBJECTS_PER_REPORT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .cfg        (cfg),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  brp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (push_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  brp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .record_out (record_out)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for blob_report_parser_top: sends report bytes and format
// writes, decodes the same bytes in a local model and compares every record.
// Depends on brp_pkg (hdl/brp_pkg.sv) and the channel interfaces (hdl/brp_ifs.sv).
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brp_pkg::*;

  localparam int OBJECTS        = 16;
  localparam int IDLE_PCT       = 23;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_BYTES   = 1040;
  localparam int MAX_PRINTED    = 100;

  // Codes with no layout of their own; the block reads them as 16-byte objects.
  localparam logic [2:0] FMT_SPARE0 = 3'd0;
  localparam logic [2:0] FMT_SPARE5 = 3'd5;
  localparam logic [2:0] FMT_SPARE6 = 3'd6;
  localparam logic [2:0] FMT_SPARE7 = 3'd7;

  typedef struct packed {
    logic [13:0] blob_area;
    logic [11:0] centroid_x;
    logic [11:0] centroid_y;
    logic        object_valid;
    logic [15:0] brightness_pair;
    logic [7:0]  range_radius;
    logic [27:0] bounds_packed;
    logic [7:0]  aspect;
    logic [15:0] velocity_pair;
    logic [3:0]  object_index;
    logic        last_object;
    logic [4:0]  valid_total;
  } blob_record_t;

  typedef enum logic [2:0] {
    FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_RANDOM, FILL_BRIGHT_ONLY, FILL_SHAPED
  } fill_t;

  typedef struct {
    bit           write_fmt;
    logic [2:0]   fmt;
    fill_t        fill;
    int           nbytes;
    int           reps;
    bit           typed;
    blob_record_t rec;
  } stim_row_t;

  localparam blob_record_t FULL_ONES = '{blob_area: 14'h3fff, centroid_x: 12'hfff,
    centroid_y: 12'hfff, object_valid: 1'b1, brightness_pair: 16'hffff,
    range_radius: 8'hff, bounds_packed: 28'hfffffff, aspect: 8'hff,
    velocity_pair: 16'hffff, object_index: 4'd0, last_object: 1'b0, valid_total: 5'd1};
  localparam blob_record_t FULL_ZEROS = '{object_index: 4'd1, valid_total: 5'd1,
    default: '0};
  localparam blob_record_t BASIC_ONES = '{blob_area: 14'h3fff, centroid_x: 12'hfff,
    centroid_y: 12'hfff, object_valid: 1'b1, object_index: 4'd2, valid_total: 5'd2,
    default: '0};

  logic clk;
  logic rst;

  report_byte_if byte_if();
  format_cfg_if  cfg_if();
  blob_record_if rec_if();

  blob_report_parser_top #(.OBJECTS_PER_REPORT(OBJECTS)) u_top (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_if),
    .cfg        (cfg_if),
    .record_out (rec_if)
  );

  // Local copy of the decoder state.
  logic [2:0]   fmt_q;
  logic [3:0]   pos_q;
  logic [3:0]   obj_q;
  logic [4:0]   valid_q;
  logic [7:0]   obj_bytes [OBJ_BYTES];
  blob_record_t pending_records [$];
  bit           typed_pending;
  blob_record_t typed_record;

  int errors;
  int bytes_sent;
  int records_checked;
  int format_writes;
  int reports_done;
  int valid_seen;
  int phases;
  bit no_idle;
  bit hold_request;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int object_length(input logic [2:0] fmt);
    case (fmt)
      FMT_BASIC:  return 6;
      FMT_BRIGHT: return 9;
      FMT_BOUNDS: return 13;
      default:    return 16;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Stores one accepted byte; on an object's final byte, queues its decoded record.
  task automatic decode_report_byte(input logic [7:0] b);
    blob_record_t r;
    int o;
    obj_bytes[pos_q] = b;
    if (int'(pos_q) < object_length(fmt_q) - 1) begin
      pos_q = pos_q + 4'd1;
      return;
    end
    pos_q = '0;
    r = '0;
    r.blob_area    = {obj_bytes[1][5:0], obj_bytes[0]};
    r.centroid_x   = {obj_bytes[3][3:0], obj_bytes[2]};
    r.centroid_y   = {obj_bytes[5][3:0], obj_bytes[4]};
    r.object_valid = (r.blob_area != '0);
    if (fmt_q == FMT_FULL || fmt_q == FMT_BRIGHT) begin
      r.brightness_pair = {obj_bytes[7], obj_bytes[6]};
      r.range_radius    = obj_bytes[8];
      if (obj_bytes[7] != 8'h00) r.object_valid = 1'b1;
    end
    if (fmt_q == FMT_FULL || fmt_q == FMT_BOUNDS) begin
      // The bounds layout sits three bytes earlier, with no brightness in front.
      o = (fmt_q == FMT_BOUNDS) ? 3 : 0;
      r.bounds_packed = {obj_bytes[12-o][6:0], obj_bytes[11-o][6:0],
                         obj_bytes[10-o][6:0], obj_bytes[9-o][6:0]};
      r.aspect        = obj_bytes[13-o];
      r.velocity_pair = {obj_bytes[15-o], obj_bytes[14-o]};
    end
    valid_q = valid_q + 5'(r.object_valid);
    r.object_index = obj_q;
    r.last_object  = (int'(obj_q) == OBJECTS - 1);
    r.valid_total  = valid_q;
    if (r.last_object) begin
      obj_q   = '0;
      valid_q = '0;
    end else begin
      obj_q = obj_q + 4'd1;
    end
    if (typed_pending) begin
      pending_records.push_back(typed_record);
      typed_pending = 1'b0;
    end else begin
      pending_records.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got_v,
                             input logic [31:0] exp_v);
    if (got_v !== exp_v)
      report_mismatch($sformatf("record %0d %s: got 0x%0h, expected 0x%0h",
                                records_checked, name, got_v, exp_v));
  endtask

  task automatic check_record();
    blob_record_t got;
    blob_record_t exp_rec;
    got = {rec_if.blob_area, rec_if.centroid_x, rec_if.centroid_y, rec_if.object_valid,
           rec_if.brightness_pair, rec_if.range_radius, rec_if.bounds_packed,
           rec_if.aspect, rec_if.velocity_pair, rec_if.object_index,
           rec_if.last_object, rec_if.valid_total};
    if (pending_records.size() == 0) begin
      report_mismatch($sformatf("record for object %0d arrived with nothing expected",
                                got.object_index));
      return;
    end
    exp_rec = pending_records.pop_front();
    records_checked++;
    if (got.last_object) reports_done++;
    if (got.object_valid) valid_seen++;
    check_field("blob_area", got.blob_area, exp_rec.blob_area);
    check_field("centroid_x", got.centroid_x, exp_rec.centroid_x);
    check_field("centroid_y", got.centroid_y, exp_rec.centroid_y);
    check_field("object_valid", got.object_valid, exp_rec.object_valid);
    check_field("brightness_pair", got.brightness_pair, exp_rec.brightness_pair);
    check_field("range_radius", got.range_radius, exp_rec.range_radius);
    check_field("bounds_packed", got.bounds_packed, exp_rec.bounds_packed);
    check_field("aspect", got.aspect, exp_rec.aspect);
    check_field("velocity_pair", got.velocity_pair, exp_rec.velocity_pair);
    check_field("object_index", got.object_index, exp_rec.object_index);
    check_field("last_object", got.last_object, exp_rec.last_object);
    check_field("valid_total", got.valid_total, exp_rec.valid_total);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      fmt_q   = FMT_FULL;
      pos_q   = '0;
      obj_q   = '0;
      valid_q = '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) fmt_q = cfg_if.report_format;
      if (byte_if.valid && byte_if.ready) decode_report_byte(byte_if.report_byte);
      if (rec_if.valid && rec_if.ready) check_record();
    end
  end

  // Record side: random stalls, plus one long hold-off when the sender asks for it.
  initial begin
    rec_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        rec_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      rec_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_if.valid && byte_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (rec_if.valid && rec_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no word moved on any channel for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      byte_if.valid <= 1'b0;
      @(posedge clk);
    end
    byte_if.valid       <= 1'b1;
    byte_if.report_byte <= b;
    @(posedge clk);
    while (!byte_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends object bytes at positions first .. first+count-1.
  task automatic send_bytes(input fill_t fill, input int first, input int count);
    bit no_area;
    bit no_bright;
    logic [7:0] b;
    no_area   = ($urandom_range(0, 3) == 0);
    no_bright = ($urandom_range(0, 2) == 0);
    for (int k = first; k < first + count; k++) begin
      case (fill)
        FILL_ZERO:        b = 8'h00;
        FILL_ONES:        b = 8'hff;
        FILL_RAMP:        b = 8'(k + 1);
        FILL_BRIGHT_ONLY: b = (k == 7) ? 8'h80 : 8'h00;
        default:          b = 8'($urandom);
      endcase
      if (fill == FILL_SHAPED) begin
        // Zero area with the upper bits of the second byte still set.
        if (no_area && k == 0) b = 8'h00;
        if (no_area && k == 1) b = b & 8'hc0;
        if (no_bright && k == 7) b = 8'h00;
      end
      send_byte(b);
    end
  endtask

  task automatic write_format(input logic [2:0] fmt);
    cfg_if.valid         <= 1'b1;
    cfg_if.report_format <= fmt;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    format_writes++;
  endtask

  // Drains every expected record and lets a partly gathered object settle.
  task automatic wait_idle();
    byte_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    stim_row_t  dir_rows [$];
    logic [2:0] fmt;
    int r;
    int n;
    int len;
    int start;
    int first;
    int cnt;
    int directed_bytes;

    rst                  <= 1'b1;
    byte_if.valid        <= 1'b0;
    byte_if.report_byte  <= 8'h00;
    cfg_if.valid         <= 1'b0;
    cfg_if.report_format <= FMT_FULL;

    // The first object runs at the reset format and fills every byte slot.
    dir_rows.push_back(stim_row_t'{1'b0, FMT_FULL, FILL_ONES, 16, 1, 1'b1, FULL_ONES});
    dir_rows.push_back(stim_row_t'{1'b0, FMT_FULL, FILL_ZERO, 16, 1, 1'b1, FULL_ZEROS});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_BASIC, FILL_ONES, 6, 1, 1'b1, BASIC_ONES});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_BRIGHT, FILL_BRIGHT_ONLY, 9, 1, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_BOUNDS, FILL_RAMP, 13, 1, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b0, FMT_BOUNDS, FILL_ONES, 13, 1, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_SPARE0, FILL_RANDOM, 16, 1, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_SPARE7, FILL_ONES, 16, 1, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_SPARE5, FILL_RANDOM, 16, 1, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_SPARE6, FILL_BRIGHT_ONLY, 16, 1, 1'b0, '0});
    // Format changes inside an object: landing exactly on, past, and short of its end.
    dir_rows.push_back(stim_row_t'{1'b1, FMT_FULL, FILL_RANDOM, 5, 1, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_BASIC, FILL_RANDOM, 1, 1, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_FULL, FILL_RANDOM, 12, 1, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_BRIGHT, FILL_RANDOM, 1, 1, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_BASIC, FILL_RAMP, 3, 1, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_FULL, FILL_RAMP, 13, 1, 1'b0, '0});
    // Objects 13 to 15 close the report; the next record starts a fresh count.
    dir_rows.push_back(stim_row_t'{1'b1, FMT_BRIGHT, FILL_RANDOM, 9, 3, 1'b0, '0});
    dir_rows.push_back(stim_row_t'{1'b1, FMT_FULL, FILL_ONES, 16, 1, 1'b1, FULL_ONES});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      for (int rep = 0; rep < dir_rows[i].reps; rep++) begin
        wait_idle();
        if (dir_rows[i].write_fmt) write_format(dir_rows[i].fmt);
        typed_record  = dir_rows[i].rec;
        typed_pending = dir_rows[i].typed;
        send_bytes(dir_rows[i].fill, int'(pos_q), dir_rows[i].nbytes);
      end
    end
    directed_bytes = bytes_sent;

    while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
      wait_idle();
      phases++;
      no_idle = (phases >= 6 && phases <= 11);
      start = int'(pos_q);
      r = $urandom_range(0, 19);
      fmt = (r < 16) ? 3'(r % 4 + 1) : 3'($urandom_range(0, 7));
      n = $urandom_range(1, 8);
      if (phases == 3) begin
        // Enough short objects to fill the record queue while the sink holds off.
        fmt = FMT_BASIC;
        n = 12;
        hold_request = 1'b1;
      end
      write_format(fmt);
      len = object_length(fmt);
      for (int k = 0; k < n; k++) begin
        first = (k == 0) ? start : 0;
        cnt = (first >= len - 1) ? 1 : len - first;
        r = $urandom_range(0, 15);
        send_bytes((r == 0) ? FILL_ZERO : ((r == 1) ? FILL_ONES : FILL_SHAPED), first, cnt);
      end
      // Sometimes stop inside an object, so the next format write lands mid-object.
      if ($urandom_range(0, 4) == 0) send_bytes(FILL_SHAPED, 0, $urandom_range(1, len - 1));
    end

    wait_idle();
    if (pending_records.size() != 0)
      report_mismatch($sformatf("%0d records never arrived", pending_records.size()));

    $display("Summary: %0d report bytes over the directed table and %0d random phases,",
             bytes_sent, phases);
    $display("Summary: %0d format writes, %0d records checked, %0d complete reports.",
             format_writes, records_checked, reports_done);
    $display("Summary: %0d objects flagged valid.", valid_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/brp_pkg.sv
hdl/brp_ifs.sv
hdl/brp_front.sv
hdl/brp_queue.sv
hdl/brp_back.sv
hdl/blob_report_parser_top.sv
verif/testbench.sv
